### sv/kts_pkg.sv
// Shared types and constants for the keyframe track sampler.
`default_nettype none
package kts_pkg;
    localparam int MaxKeys  = 64;
    localparam int IdxW     = $clog2(MaxKeys);
    localparam int CntW     = IdxW + 1;
    localparam int TimeW    = 17;
    localparam int ValW     = 32;
    localparam int STimeW   = 18;
    localparam int QueueDepth = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Byte address of the key count register.
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic              is_sample;
        logic [IdxW-1:0]   key_index;
        logic [TimeW-1:0]  key_time;
        logic [ValW-1:0]   key_value;
        logic              key_is_step;
        logic [TimeW-1:0]  t;
    } t_cmd;
endpackage
`default_nettype wire

### sv/kts_front.sv
// Front part: accepts items, clamps the sample time, and queues commands.
`default_nettype none
module kts_front import kts_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  wire               i_op,
    input  wire [IdxW-1:0]    i_key_index,
    input  wire [TimeW-1:0]   i_key_time,
    input  wire signed [ValW-1:0] i_key_value,
    input  wire               i_key_is_step,
    input  wire signed [STimeW-1:0] i_sample_time,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  wire               i_cmd_take
);
    t_cmd r_q [QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd w_cmd;
    logic w_push, w_pop;

    // Clamp sample time to 0..1.0 and build the command.
    always_comb begin
        w_cmd.is_sample   = (i_op == OP_SAMPLE);
        w_cmd.key_index   = i_key_index;
        w_cmd.key_time    = i_key_time;
        w_cmd.key_value   = i_key_value;
        w_cmd.key_is_step = i_key_is_step;
        if (i_sample_time < 0) w_cmd.t = '0;
        else if (i_sample_time > 18'sd65536) w_cmd.t = TimeW'(65536);
        else w_cmd.t = i_sample_time[TimeW-1:0];
    end

    assign o_full      = (r_cnt == 2'(QueueDepth));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_push && !o_full;
    assign w_pop       = i_cmd_take && o_cmd_valid;

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) r_q[r_wp] <= w_cmd;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QueueDepth)) else $error("queue count overflow");
    a_full_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_pop |=> o_full) else $error("full queue lost an entry");
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd_valid && !i_push |=> !o_cmd_valid) else $error("entry invented");
endmodule
`default_nettype wire

### sv/kts_back.sv
// Back part: key store, binary search, serial divider and interpolation.
`default_nettype none
module kts_back import kts_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire [CntW-1:0]    i_key_count,
    input  wire               i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_take,
    output logic              o_empty,
    input  wire               i_pop,
    output logic signed [ValW-1:0] o_sampled_value
);
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRD, S_RD0, S_RD1, S_CHK, S_DIV, S_MUL, S_ADD, S_OUT
    } t_state;

    logic [TimeW-1:0] r_tmem [MaxKeys];
    logic [ValW-1:0]  r_vmem [MaxKeys];
    logic             r_smem [MaxKeys];
    logic [TimeW-1:0] r_rt;
    logic [ValW-1:0]  r_rv;
    logic             r_rs;

    t_state r_st;
    logic [TimeW-1:0] r_t;
    logic [CntW-1:0] r_lo, r_span, r_n, r_probe;
    logic [TimeW-1:0] r_tk0;
    logic signed [ValW-1:0] r_v0;
    logic r_s0;
    logic [TimeW-1:0] r_num, r_den;
    logic [TimeW:0] r_rem;
    logic [16:0] r_alpha;
    logic [4:0] r_bit;
    logic signed [ValW:0] r_diff;
    logic signed [ValW+17:0] r_prod;
    logic signed [ValW-1:0] r_res;
    logic r_full;
    logic [IdxW-1:0] w_addr;
    logic [CntW-1:0] w_half;
    logic [TimeW:0] w_rem2;
    logic signed [ValW+17:0] w_s;

    assign o_empty = !r_full;
    assign o_sampled_value = r_res;
    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid && (!i_cmd.is_sample || !r_full);
    assign w_half = r_span >> 1;
    assign w_rem2 = {r_rem[TimeW-1:0], 1'b0};
    assign w_s = r_prod + (ValW+18)'(32768);

    // Read address follows the sequencer step; a time before the first key uses key 0.
    always_comb begin
        unique case (r_st)
            S_SRCH:  w_addr = r_probe[IdxW-1:0];
            S_RD0:   w_addr = (r_lo == '0) ? '0 : IdxW'(r_lo - 1'b1);
            default: w_addr = r_lo[IdxW-1:0];
        endcase
    end

    // Key store with registered read.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take && !i_cmd.is_sample) begin
            r_tmem[i_cmd.key_index] <= i_cmd.key_time;
            r_vmem[i_cmd.key_index] <= i_cmd.key_value;
            r_smem[i_cmd.key_index] <= i_cmd.key_is_step;
        end
        r_rt <= r_tmem[w_addr];
        r_rv <= r_vmem[w_addr];
        r_rs <= r_smem[w_addr];
    end

    // Sample sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_full <= 1'b0;
        end else begin
            // The result register fills when the sequencer finishes and drains on pop.
            if ((r_st == S_OUT) && (!r_full || i_pop)) r_full <= 1'b1;
            else if (i_pop && r_full) r_full <= 1'b0;
            unique case (r_st)
                S_IDLE: if (o_cmd_take && i_cmd.is_sample) begin
                    r_t <= i_cmd.t;
                    r_lo <= '0;
                    r_n <= i_key_count;
                    r_span <= i_key_count;
                    r_probe <= i_key_count >> 1;
                    if (i_key_count == '0) begin
                        r_res <= '0;
                        r_st <= S_OUT;
                    end else r_st <= S_SRCH;
                end
                S_SRCH: r_st <= S_SRD;
                S_SRD: begin
                    // One probe of the upper-bound search.
                    if (r_rt <= r_t) begin
                        r_lo <= r_probe + 1'b1;
                        r_span <= r_span - w_half - 1'b1;
                        r_probe <= r_probe + 1'b1 + ((r_span - w_half - 1'b1) >> 1);
                        if (r_span - w_half - 1'b1 == '0) r_st <= S_RD0;
                        else r_st <= S_SRCH;
                    end else begin
                        r_span <= w_half;
                        r_probe <= r_lo + (w_half >> 1);
                        if (w_half == '0) r_st <= S_RD0;
                        else r_st <= S_SRCH;
                    end
                end
                S_RD0: begin
                    if (r_lo == '0) r_lo <= CntW'(1);
                    r_st <= S_RD1;
                end
                S_RD1: begin
                    r_tk0 <= r_rt;
                    r_v0 <= r_rv;
                    r_s0 <= r_rs;
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    // Hold, or prepare the alpha division.
                    if (r_s0 || r_lo >= r_n || r_rt <= r_tk0) begin
                        r_res <= r_v0;
                        r_st <= S_OUT;
                    end else begin
                        r_num <= (r_t >= r_tk0) ? r_t - r_tk0 : '0;
                        r_den <= r_rt - r_tk0;
                        r_diff <= $signed({r_rv[ValW-1], r_rv}) - $signed({r_v0[ValW-1], r_v0});
                        r_rem <= '0;
                        r_alpha <= '0;
                        r_bit <= 5'd0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_bit == 5'd0) begin
                        if (r_num >= r_den) begin
                            r_alpha <= 17'd65536;
                            r_st <= S_MUL;
                        end else begin
                            r_rem <= {1'b0, r_num};
                            r_bit <= 5'd1;
                        end
                    end else begin
                        // One quotient bit per cycle.
                        if (w_rem2 >= {1'b0, r_den}) begin
                            r_rem <= w_rem2 - {1'b0, r_den};
                            r_alpha <= {r_alpha[15:0], 1'b1};
                        end else begin
                            r_rem <= w_rem2;
                            r_alpha <= {r_alpha[15:0], 1'b0};
                        end
                        if (r_bit == 5'd16) r_st <= S_MUL;
                        r_bit <= r_bit + 5'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= (ValW+18)'(r_diff * $signed({1'b0, r_alpha}));
                    r_st <= S_ADD;
                end
                S_ADD: begin
                    r_res <= r_v0 + ValW'(w_s >>> 16);
                    r_st <= S_OUT;
                end
                S_OUT: if (!r_full || i_pop) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_one_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) && !r_full |=> r_full) else $error("result lost");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == S_IDLE) else $error("take while busy");
    a_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SRCH) |-> r_span != '0) else $error("empty search span");
endmodule
`default_nettype wire

### sv/keyframe_track_sampler.sv
// Top level of the keyframe track sampler.
// A load beat writes one key when the back part takes it. A sample beat runs one
// binary-search probe per S_SRCH/S_SRD pass (up to 7 probes over 64 keys), fetches
// the bracketing keys in S_RD0, S_RD1 and S_CHK, forms alpha by serial division in
// S_DIV, then multiplies in S_MUL, adds with rounding in S_ADD and writes the result
// in S_OUT. The back part takes a new command only while its sequencer is idle. The
// single read port of the key store and the one-bit-per-cycle divider set its pace.
// A two-entry queue decouples input from the sequencer; one result register feeds
// the output, and a sample waits in the queue while a result is unread.
`default_nettype none
module keyframe_track_sampler import kts_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire               i_op,
    input  wire [IdxW-1:0]    i_key_index,
    input  wire [TimeW-1:0]   i_key_time,
    input  wire signed [ValW-1:0] i_key_value,
    input  wire               i_key_is_step,
    input  wire signed [STimeW-1:0] i_sample_time,
    output logic              empty,
    input  wire               pop,
    output logic signed [ValW-1:0] o_sampled_value,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [1:0]         paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [CntW-1:0] r_key_count;
    logic w_cv, w_take;
    t_cmd w_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_KEY_COUNT) ? 32'(r_key_count) : '0;

    // Key count register, saturated to the store depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_key_count <= '0;
        else if (psel && penable && pwrite && paddr == REG_KEY_COUNT)
            r_key_count <= (pwdata[6:0] > 7'(MaxKeys)) ? CntW'(MaxKeys) : CntW'(pwdata[6:0]);
    end

    kts_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_op, .i_key_index,
        .i_key_time, .i_key_value, .i_key_is_step, .i_sample_time,
        .o_cmd_valid(w_cv), .o_cmd(w_cmd), .i_cmd_take(w_take)
    );

    kts_back u_back (
        .i_clk, .i_rst_n, .i_key_count(r_key_count), .i_cmd_valid(w_cv),
        .i_cmd(w_cmd), .o_cmd_take(w_take), .o_empty(empty), .i_pop(pop),
        .o_sampled_value
    );
endmodule
`default_nettype wire

### bench/keyframe_track_sampler_tb.sv
// Self-checking testbench for the keyframe track sampler.
`default_nettype none
module keyframe_track_sampler_tb;
    import kts_pkg::*;

    localparam int DrainCycles = 100;
    localparam int CycleLimit  = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic i_op = OP_LOAD;
    logic [IdxW-1:0] i_key_index = '0;
    logic [TimeW-1:0] i_key_time = '0;
    logic signed [ValW-1:0] i_key_value = '0;
    logic i_key_is_step = 1'b0;
    logic signed [STimeW-1:0] i_sample_time = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [ValW-1:0] o_sampled_value;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // Shadow copy of the key store and the key count.
    logic [TimeW-1:0] key_times[MaxKeys];
    logic signed [ValW-1:0] key_vals[MaxKeys];
    logic key_steps[MaxKeys];
    int track_len = 0;

    logic signed [ValW-1:0] pending_values[$];
    int errors = 0;
    int cycles = 0;
    bit stalls_off = 1'b0;
    bit running = 1'b0;

    keyframe_track_sampler DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Global watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("keyframe_track_sampler_tb failed");
            $finish;
        end
    end

    // Predicts the sampled value for a raw signed sample time.
    function automatic logic signed [ValW-1:0] predict_sample(logic signed [STimeW-1:0] st);
        int t, lo, span, half, probe, i0, i1;
        longint num, den, alpha, v0, v1, s;
        if (st < 0) t = 0;
        else if (st > 65536) t = 65536;
        else t = int'(st);
        if (track_len == 0) return '0;
        lo = 0;
        span = track_len;
        while (span > 0) begin
            half = span / 2;
            probe = lo + half;
            if (int'(key_times[probe]) <= t) begin
                lo = probe + 1;
                span -= half + 1;
            end else begin
                span = half;
            end
        end
        i1 = lo;
        if (i1 == 0) return key_vals[0];
        i0 = i1 - 1;
        if (key_steps[i0] || i1 >= track_len) return key_vals[i0];
        if (key_times[i1] <= key_times[i0]) return key_vals[i0];
        num = (t >= int'(key_times[i0])) ? longint'(t) - key_times[i0] : 0;
        den = longint'(key_times[i1]) - key_times[i0];
        alpha = (num >= den) ? 65536 : (num << 16) / den;
        v0 = key_vals[i0];
        v1 = key_vals[i1];
        // Round to nearest, ties toward plus infinity: floor of (p + half).
        s = (v1 - v0) * alpha + 32768;
        return ValW'(v0 + (s >>> 16));
    endfunction

    // Sends one beat, waiting a random gap first, and records the key or the prediction.
    task automatic send_item(logic op, logic [IdxW-1:0] idx, logic [TimeW-1:0] kt,
                             logic signed [ValW-1:0] kv, logic ks,
                             logic signed [STimeW-1:0] st);
        int gap;
        gap = stalls_off ? 0 : $urandom_range(16);
        repeat (gap) @(negedge i_clk);
        push = 1'b1;
        i_op = op;
        i_key_index = idx;
        i_key_time = kt;
        i_key_value = kv;
        i_key_is_step = ks;
        i_sample_time = st;
        do @(posedge i_clk); while (full);
        if (op == OP_LOAD) begin
            key_times[idx] = kt;
            key_vals[idx] = kv;
            key_steps[idx] = ks;
        end else begin
            pending_values.push_back(predict_sample(st));
        end
        @(negedge i_clk);
        push = 1'b0;
    endtask

    task automatic load_key(int idx, int kt, logic signed [ValW-1:0] kv, bit ks);
        send_item(OP_LOAD, idx[IdxW-1:0], kt[TimeW-1:0], kv, ks, STimeW'($urandom));
    endtask

    task automatic sample_at(logic signed [STimeW-1:0] st);
        send_item(OP_SAMPLE, IdxW'($urandom), TimeW'($urandom), ValW'($urandom),
                  1'($urandom), st);
    endtask

    // Waits until all results are back, then lets trailing work finish.
    task automatic wait_idle();
        while (pending_values.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // Writes the key count register while the block is idle.
    task automatic write_key_count(int unsigned value);
        wait_idle();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_KEY_COUNT;
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        track_len = ((value & 32'h7f) > MaxKeys) ? MaxKeys : int'(value & 32'h7f);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Loads all slots with an ascending track; some neighbors share a time.
    task automatic load_ascending_track();
        int t;
        t = $urandom_range(2000);
        for (int k = 0; k < MaxKeys; k++) begin
            load_key(k, t, ValW'($urandom), ($urandom_range(3) == 0));
            if ($urandom_range(7) != 0) t += $urandom_range(2048);
            if (t > 65536) t = 65536;
        end
    endtask

    function automatic logic signed [STimeW-1:0] random_sample_time();
        int pick;
        pick = $urandom_range(9);
        if (pick < 5) return STimeW'($urandom_range(65536));
        if (pick < 8 && track_len > 0)
            return STimeW'(int'(key_times[$urandom_range(track_len - 1)])
                           + int'($urandom_range(4)) - 2);
        return STimeW'($urandom);
    endfunction

    // Empty track, extremes of times and values, duplicate times, step keys.
    task automatic test_directed();
        sample_at(18'sh0);
        sample_at(18'sh1ffff);
        load_key(0, 'h1000, 32'sh7fffffff, 1'b0);
        load_key(1, 'h8000, 32'sh80000000, 1'b0);
        load_key(2, 'h8000, 32'sh00010000, 1'b1);
        load_key(3, 'h10000, 32'shffff0000, 1'b0);
        write_key_count(4);
        sample_at(18'sh20000);
        sample_at(18'sh0800);
        sample_at(18'sh1000);
        sample_at(18'sh4800);
        sample_at(18'sh7fff);
        sample_at(18'sh8000);
        sample_at(18'shc000);
        sample_at(18'sh10000);
        sample_at(18'sh1ffff);
        // Keys out of order: later key earlier than the one before it.
        load_key(1, 'h0800, 32'sh00020000, 1'b0);
        sample_at(18'sh0c00);
        sample_at(18'sh0400);
        write_key_count(1);
        sample_at(18'sh0);
        sample_at(18'sh2000);
    endtask

    // Random phases over several key counts, the extremes among them.
    task automatic test_random_phases();
        int unsigned counts[7] = '{64, 0, 1, 2, 127, 65, 0};
        for (int p = 0; p < 7; p++) begin
            stalls_off = (p == 3);
            load_ascending_track();
            write_key_count((p == 6) ? $urandom_range(3, 63) : counts[p]);
            for (int k = 0; k < 215; k++) begin
                if ($urandom_range(5) == 0)
                    load_key($urandom_range(MaxKeys - 1), $urandom_range(65536),
                             ValW'($urandom), 1'($urandom_range(1)));
                else
                    sample_at(random_sample_time());
            end
        end
        stalls_off = 1'b0;
    endtask

    // Result consumer with random stalls.
    initial begin
        int gap;
        wait (running);
        forever begin
            @(negedge i_clk);
            gap = stalls_off ? 0 : $urandom_range(16);
            pop = (gap == 0);
            repeat (gap) @(negedge i_clk);
            pop = 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // Compares each popped beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result beat: sampled_value actual %0d", o_sampled_value);
                errors++;
            end else begin
                if (o_sampled_value !== pending_values[0]) begin
                    $error("sampled_value expected %0d actual %0d",
                           pending_values[0], o_sampled_value);
                    errors++;
                end
                void'(pending_values.pop_front());
            end
        end
    end

    initial begin
        for (int k = 0; k < MaxKeys; k++) begin
            key_times[k] = '0;
            key_vals[k] = '0;
            key_steps[k] = 1'b0;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;
        test_directed();
        test_random_phases();
        wait_idle();
        if (errors == 0 && pending_values.size() == 0) begin
            $display("keyframe_track_sampler_tb passed");
        end else begin
            $display("keyframe_track_sampler_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
